FILE: hdl/rau_pkg.sv
// Shared constants for the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;
  localparam int OPERAND_BITS_DEF = 32;
  localparam int MAG_W  = 64;
  localparam int WIDE_W = 65;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;
endpackage

FILE: hdl/rational_arithmetic_unit_core.sv
// Rational arithmetic unit: signed fractions, add/sub/mul/div, gcd-reduced result.
// Every division runs on the shared divider, which produces 65 quotient bits;
//   each Euclid step is one division, and a zero-denominator or divide-by-zero
//   item finishes without a division.
// Throughput: one item at a time; busy stays high until done pulses.
// Reset: synchronous active-high rst returns the sequencer to idle.
// Results appear for one cycle with done; the receiver cannot stall.
`timescale 1ns / 1ps
module rational_arithmetic_unit_core #(
  parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [31:0] a_num,
  input  logic [31:0] a_den,
  input  logic        a_neg,
  input  logic [31:0] b_num,
  input  logic [31:0] b_den,
  input  logic        b_neg,
  output logic        done,
  output logic [63:0] res_num,
  output logic [63:0] res_den,
  output logic        res_neg,
  output logic [1:0]  status
);
  import rau_pkg::*;

  localparam int P = OPERAND_BITS;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_MULA  = 5'd1;
  localparam logic [4:0] S_MULB  = 5'd2;
  localparam logic [4:0] S_GCD   = 5'd3;
  localparam logic [4:0] S_GSTEP = 5'd4;
  localparam logic [4:0] S_DWAIT = 5'd5;
  localparam logic [4:0] S_G1    = 5'd6;
  localparam logic [4:0] S_A1    = 5'd7;
  localparam logic [4:0] S_A2    = 5'd8;
  localparam logic [4:0] S_A3    = 5'd9;
  localparam logic [4:0] S_A4    = 5'd10;
  localparam logic [4:0] S_A5    = 5'd11;
  localparam logic [4:0] S_A6    = 5'd12;
  localparam logic [4:0] S_RED   = 5'd13;
  localparam logic [4:0] S_R1    = 5'd14;
  localparam logic [4:0] S_R2    = 5'd15;
  localparam logic [4:0] S_R3    = 5'd16;
  localparam logic [4:0] S_R4    = 5'd17;

  logic [4:0]        state, ret, gret;
  logic [1:0]        op;
  logic [P-1:0]      an, ad, bn, bd, fa, fb;
  logic              as, bs;
  logic [MAG_W-1:0]  gx, gy, la, lb, dreg, g;
  logic [WIDE_W-1:0] nreg;
  logic              nneg;

  logic              div_start, div_done;
  logic [WIDE_W-1:0] dvd, div_q;
  logic [MAG_W-1:0]  dvs, div_r;

  logic [P-1:0]      mul_a, mul_b;
  logic [2*P-1:0]    prod;
  logic [MAG_W-1:0]  prod64;

  logic [P-1:0]      in_an, in_ad, in_bn, in_bd;
  logic              sub_bs;

  assign in_an = a_num[P-1:0];
  assign in_ad = a_den[P-1:0];
  assign in_bn = b_num[P-1:0];
  assign in_bd = b_den[P-1:0];
  assign busy  = state != S_IDLE;
  assign sub_bs = (op == KIND_SUB) ? !bs : bs;

  rau_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (dvd),
    .divisor   (dvs),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_comb begin
    mul_a = an;
    mul_b = bn;
    case (state)
      S_MULA: begin
        mul_a = an;
        mul_b = (op == KIND_MUL) ? bn : bd;
      end
      S_MULB: begin
        mul_a = ad;
        mul_b = (op == KIND_MUL) ? bd : bn;
      end
      S_A3: begin
        mul_a = an;
        mul_b = fa;
      end
      S_A4: begin
        mul_a = bn;
        mul_b = fb;
      end
      S_A5: begin
        mul_a = fb;
        mul_b = bd;
      end
      default: begin
        mul_a = an;
        mul_b = bn;
      end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign prod64 = MAG_W'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      div_start <= 1'b0;
    end else begin
      done      <= 1'b0;
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op <= kind;
            an <= in_an;
            ad <= in_ad;
            bn <= in_bn;
            bd <= in_bd;
            as <= a_neg;
            bs <= b_neg;
            if (in_ad == '0 || in_bd == '0) begin
              res_num <= '0;
              res_den <= '0;
              res_neg <= 1'b0;
              status  <= ST_ZERO_DEN;
              done    <= 1'b1;
            end else if (kind == KIND_DIV && in_bn == '0) begin
              res_num <= '0;
              res_den <= '0;
              res_neg <= 1'b0;
              status  <= ST_DIV_ZERO;
              done    <= 1'b1;
            end else if (kind == KIND_MUL || kind == KIND_DIV) begin
              state <= S_MULA;
            end else begin
              gx    <= MAG_W'(in_ad);
              gy    <= MAG_W'(in_bd);
              gret  <= S_G1;
              state <= S_GCD;
            end
          end
        end
        S_MULA: begin
          nreg  <= WIDE_W'(prod64);
          nneg  <= as ^ bs;
          state <= S_MULB;
        end
        S_MULB: begin
          dreg  <= prod64;
          state <= S_RED;
        end
        S_GCD: begin
          if (gy == '0) begin
            g     <= gx;
            state <= gret;
          end else begin
            dvd       <= WIDE_W'(gx);
            dvs       <= gy;
            div_start <= 1'b1;
            ret       <= S_GSTEP;
            state     <= S_DWAIT;
          end
        end
        S_GSTEP: begin
          gx    <= gy;
          gy    <= div_r;
          state <= S_GCD;
        end
        S_DWAIT: begin
          if (div_done) begin
            state <= ret;
          end
        end
        S_G1: begin
          dvd       <= WIDE_W'(bd);
          dvs       <= g;
          div_start <= 1'b1;
          ret       <= S_A1;
          state     <= S_DWAIT;
        end
        S_A1: begin
          fa        <= div_q[P-1:0];
          dvd       <= WIDE_W'(ad);
          dvs       <= g;
          div_start <= 1'b1;
          ret       <= S_A2;
          state     <= S_DWAIT;
        end
        S_A2: begin
          fb    <= div_q[P-1:0];
          state <= S_A3;
        end
        S_A3: begin
          la    <= prod64;
          state <= S_A4;
        end
        S_A4: begin
          lb    <= prod64;
          state <= S_A5;
        end
        S_A5: begin
          dreg  <= prod64;
          state <= S_A6;
        end
        S_A6: begin
          // signed combine, one carry bit on a like-sign sum
          if (as == sub_bs) begin
            nreg <= {1'b0, la} + {1'b0, lb};
            nneg <= as;
          end else if (la >= lb) begin
            nreg <= {1'b0, la - lb};
            nneg <= as;
          end else begin
            nreg <= {1'b0, lb - la};
            nneg <= sub_bs;
          end
          state <= S_RED;
        end
        S_RED: begin
          if (nreg == '0) begin
            res_num <= '0;
            res_den <= 64'd1;
            res_neg <= 1'b0;
            status  <= ST_OK;
            done    <= 1'b1;
            state   <= S_IDLE;
          end else begin
            dvd       <= nreg;
            dvs       <= dreg;
            div_start <= 1'b1;
            ret       <= S_R1;
            state     <= S_DWAIT;
          end
        end
        S_R1: begin
          gx    <= dreg;
          gy    <= div_r;
          gret  <= S_R2;
          state <= S_GCD;
        end
        S_R2: begin
          if (nreg[WIDE_W-1] && g < 64'd2) begin
            res_num <= '0;
            res_den <= '0;
            res_neg <= 1'b0;
            status  <= ST_OVERFLOW;
            done    <= 1'b1;
            state   <= S_IDLE;
          end else begin
            dvd       <= nreg;
            dvs       <= g;
            div_start <= 1'b1;
            ret       <= S_R3;
            state     <= S_DWAIT;
          end
        end
        S_R3: begin
          res_num   <= div_q[MAG_W-1:0];
          dvd       <= WIDE_W'(dreg);
          dvs       <= g;
          div_start <= 1'b1;
          ret       <= S_R4;
          state     <= S_DWAIT;
        end
        S_R4: begin
          res_den <= div_q[MAG_W-1:0];
          res_neg <= nneg;
          status  <= ST_OK;
          done    <= 1'b1;
          state   <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

FILE: hdl/rau_div.sv
// Restoring divider, one quotient bit per cycle, 65-bit dividend.
`timescale 1ns / 1ps
module rau_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rau_pkg::WIDE_W-1:0] dividend,
  input  logic [rau_pkg::MAG_W-1:0]  divisor,
  output logic                       done,
  output logic [rau_pkg::WIDE_W-1:0] quotient,
  output logic [rau_pkg::MAG_W-1:0]  remainder
);
  import rau_pkg::*;

  localparam logic [6:0] LAST = 7'(WIDE_W - 1);

  logic              run;
  logic [6:0]        cnt;
  logic [MAG_W-1:0]  dvs;
  logic [WIDE_W-1:0] trial;
  logic              fits;

  assign trial = {remainder, quotient[WIDE_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run       <= 1'b1;
        cnt       <= '0;
        dvs       <= divisor;
        quotient  <= dividend;
        remainder <= '0;
      end else if (run) begin
        remainder <= fits ? MAG_W'(trial - {1'b0, dvs}) : trial[MAG_W-1:0];
        quotient  <= {quotient[WIDE_W-2:0], fits};
        cnt       <= cnt + 7'd1;
        if (cnt == LAST) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the rational arithmetic unit core.
`timescale 1ns / 1ps
module tb_top;
  import rau_pkg::*;

  typedef struct packed {
    logic [63:0] num;
    logic [63:0] den;
    logic        neg;
    logic [1:0]  st;
  } fraction_t;

  class fraction_scoreboard;
    fraction_t pending_q[$];
    int        errors;

    function automatic logic [64:0] gcd65(logic [64:0] x, logic [64:0] y);
      logic [64:0] t;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      return x;
    endfunction

    // Exact fraction result: sums are carried in 65 bits, then reduced.
    function automatic fraction_t compute_fraction(logic [1:0] op, logic [31:0] an,
                                                   logic [31:0] ad, logic an_neg,
                                                   logic [31:0] bn, logic [31:0] bd,
                                                   logic bn_neg);
      fraction_t   r;
      logic [64:0] n;
      logic [64:0] g;
      logic [64:0] q;
      logic [63:0] d;
      logic [63:0] cd;
      logic [63:0] la;
      logic [63:0] lb;
      logic        neg;
      logic        bs;
      r = '0;
      if (ad == 0 || bd == 0) begin
        r.st = ST_ZERO_DEN;
        return r;
      end
      bs = bn_neg;
      case (op)
        KIND_MUL: begin
          n = 65'(64'(an) * 64'(bn));
          d = 64'(ad) * 64'(bd);
          neg = an_neg ^ bn_neg;
        end
        KIND_DIV: begin
          if (bn == 0) begin
            r.st = ST_DIV_ZERO;
            return r;
          end
          n = 65'(64'(an) * 64'(bd));
          d = 64'(ad) * 64'(bn);
          neg = an_neg ^ bn_neg;
        end
        default: begin
          g = gcd65(65'(ad), 65'(bd));
          cd = 64'(ad) / g[63:0] * 64'(bd);
          la = 64'(an) * (cd / 64'(ad));
          lb = 64'(bn) * (cd / 64'(bd));
          d = cd;
          if (op == KIND_SUB) bs = ~bs;
          if (an_neg == bs) begin
            n = 65'(la) + 65'(lb);
            neg = an_neg;
          end else if (la >= lb) begin
            n = 65'(la - lb);
            neg = an_neg;
          end else begin
            n = 65'(lb - la);
            neg = bs;
          end
        end
      endcase
      if (n == 0) begin
        r.den = 64'd1;
        r.st = ST_OK;
        return r;
      end
      g = gcd65(n, 65'(d));
      q = n / g;
      if (q[64]) begin
        r.st = ST_OVERFLOW;
        return r;
      end
      r.num = q[63:0];
      r.den = d / g[63:0];
      r.neg = neg;
      r.st = ST_OK;
      return r;
    endfunction

    function void note_transfer(logic [1:0] op, logic [31:0] an, logic [31:0] ad,
                                logic an_neg, logic [31:0] bn, logic [31:0] bd,
                                logic bn_neg);
      pending_q.push_back(compute_fraction(op, an, ad, an_neg, bn, bd, bn_neg));
    endfunction

    function void report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void check_result(fraction_t got);
      fraction_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("result with nothing pending: %h/%h neg=%b st=%0d",
                         got.num, got.den, got.neg, got.st));
        return;
      end
      want = pending_q.pop_front();
      if (got.num != want.num) report($sformatf("res_num %h, want %h", got.num, want.num));
      if (got.den != want.den) report($sformatf("res_den %h, want %h", got.den, want.den));
      if (got.neg != want.neg) report($sformatf("res_neg %b, want %b", got.neg, want.neg));
      if (got.st != want.st) report($sformatf("status %0d, want %0d", got.st, want.st));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  kind;
  logic [31:0] a_num;
  logic [31:0] a_den;
  logic        a_neg;
  logic [31:0] b_num;
  logic [31:0] b_den;
  logic        b_neg;
  logic        done;
  logic [63:0] res_num;
  logic [63:0] res_den;
  logic        res_neg;
  logic [1:0]  status;

  fraction_scoreboard sb = new();

  rational_arithmetic_unit_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .a_num(a_num), .a_den(a_den), .a_neg(a_neg),
    .b_num(b_num), .b_den(b_den), .b_neg(b_neg),
    .done(done), .res_num(res_num), .res_den(res_den), .res_neg(res_neg),
    .status(status)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) sb.check_result('{res_num, res_den, res_neg, status});
  end

  // Leaves start high; the caller lowers it when no item follows.
  task automatic send_fraction(logic [1:0] op, logic [31:0] an, logic [31:0] ad,
                               logic an_neg, logic [31:0] bn, logic [31:0] bd,
                               logic bn_neg);
    start <= 1'b1;
    kind <= op;
    a_num <= an;
    a_den <= ad;
    a_neg <= an_neg;
    b_num <= bn;
    b_den <= bd;
    b_neg <= bn_neg;
    do @(posedge clk); while (busy);
    sb.note_transfer(op, an, ad, an_neg, bn, bd, bn_neg);
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 6))
      0: return 32'($urandom_range(0, 12));
      1: return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
      2: return $urandom >> $urandom_range(0, 31);
      3: return 32'(1) << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_den();
    logic [31:0] v;
    if ($urandom_range(0, 40) == 0) return 32'd0;
    v = pick_value();
    return (v == 0) ? 32'd1 : v;
  endfunction

  initial begin
    logic [1:0] ops[4];
    int         n_random;
    ops = '{KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV};
    rst = 1'b1;
    start = 1'b0;
    kind = KIND_ADD;
    a_num = '0;
    a_den = '0;
    a_neg = 1'b0;
    b_num = '0;
    b_den = '0;
    b_neg = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every op, extremes, zero denominators, divide by zero,
    // negative zero, unreduced operands, large sums that carry out.
    foreach (ops[i]) begin
      send_fraction(ops[i], 32'd3, 32'd4, 1'b0, 32'd5, 32'd6, 1'b1);
      send_fraction(ops[i], 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                    32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1);
      send_fraction(ops[i], 32'd0, 32'd7, 1'b1, 32'd0, 32'd9, 1'b1);
    end
    send_fraction(KIND_ADD, 32'd1, 32'd0, 1'b0, 32'd1, 32'd1, 1'b0);
    send_fraction(KIND_MUL, 32'd1, 32'd1, 1'b1, 32'd1, 32'd0, 1'b0);
    send_fraction(KIND_DIV, 32'd5, 32'd3, 1'b0, 32'd0, 32'd2, 1'b1);
    send_fraction(KIND_SUB, 32'd6, 32'd8, 1'b0, 32'd3, 32'd4, 1'b0);
    send_fraction(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 1'b0,
                  32'hFFFF_FFFF, 32'hFFFF_FFFD, 1'b0);
    send_fraction(KIND_SUB, 32'hFFFF_FFFF, 32'd1, 1'b0, 32'hFFFF_FFFF, 32'd1, 1'b1);
    send_fraction(KIND_DIV, 32'hFFFF_FFFF, 32'd1, 1'b1, 32'd1, 32'hFFFF_FFFF, 1'b0);
    send_fraction(KIND_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

    // Sender holds off until everything has drained.
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);

    n_random = 1200;
    for (int i = 0; i < n_random; i++) begin
      if (i < n_random - 150 && $urandom_range(0, 5) == 0)
        pause_sender($urandom_range(1, 18));
      send_fraction(2'($urandom), pick_value(), pick_den(), 1'($urandom),
                    pick_value(), pick_den(), 1'($urandom));
    end
    start <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("timeout with %0d results outstanding", sb.pending_q.size());
    $display("tb_top NOT OK");
    $finish;
  end
endmodule

FILE: sim.f
hdl/rau_pkg.sv
hdl/rau_div.sv
hdl/rational_arithmetic_unit_core.sv
test/tb_top.sv
